// ----- src/mar_pkg.sv -----
// Package for the moving-average range block: sizes, beat types, the
// controller state type and the command and status groups.
// Depends on nothing; every other file imports it.
package mar_pkg;

   // Delay line depth and sample width.
   localparam int WINDOW_MAX  = 64;
   localparam int SAMPLE_BITS = 16;

   // Fixed widths of the register and the result field.
   localparam int CSR_BITS = 7;
   localparam int OUT_BITS = 24;
   localparam int FRAC_EXTRA = 8;

   // Derived sizes.
   localparam int ADDR_BITS = (WINDOW_MAX > 2) ? $clog2(WINDOW_MAX) : 1;
   localparam int LEN_BITS  = $clog2(WINDOW_MAX) + 1;
   localparam int EXT_BITS  = (LEN_BITS > CSR_BITS) ? LEN_BITS : CSR_BITS;
   localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1;
   localparam int DIV_BITS  = SUM_BITS + FRAC_EXTRA;
   localparam int CNT_BITS  = $clog2(DIV_BITS);

   // One input beat.
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [OUT_BITS-1:0] avg_spread;
      logic                had_window;
   } rsp_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SUM,
      ST_CMP,
      ST_LOAD,
      ST_DIV,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic cfg_write;
      logic mem_read;
      logic sum_update;
      logic cmp_update;
      logic div_start;
      logic div_step;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic item_last;
      logic div_last;
      logic out_busy;
   } status_type;

endpackage

// ----- src/mar_ctrl.sv -----
// Controller of the moving-average range block: sequences one sample
// through read, sum, compare and, on the last beat, the serial divide.
// Depends on mar_pkg.
module mar_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  mar_pkg::status_type status,
   output mar_pkg::cmd_type    cmd
);
   import mar_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      csr_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            csr_ready     = 1'b1;
            cmd.cfg_write = csr_valid;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_update = 1'b1;
            state_in       = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp_update = 1'b1;
            state_in       = status.item_last ? ST_LOAD : ST_IDLE;
         end
         ST_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold the quotient until the output register is free.
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // A quotient is only loaded after the divide has run.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> $past(state_ff) == ST_DIV || $past(state_ff) == ST_DONE)
      else $error("result loaded without a finished divide");

   // The divide starts only after a compare of a last beat.
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> $past(state_ff) == ST_CMP && status.item_last)
      else $error("divide started without a last beat");

   // A captured beat always goes on to the read step.
   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == ST_READ)
      else $error("captured beat did not enter the read step");
`endif

endmodule

// ----- src/mar_datapath.sv -----
// Datapath of the moving-average range block: delay line memory, running
// sum, min and max window sums, restoring divider and result register.
// Depends on mar_pkg.
module mar_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  mar_pkg::cmd_type          cmd,
   output mar_pkg::status_type       status,
   input  mar_pkg::req_type          req_data,
   input  logic [mar_pkg::CSR_BITS-1:0] csr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mar_pkg::rsp_type          rsp_data
);
   import mar_pkg::*;

   // Delay line memory and its registered read data.
   logic signed [SAMPLE_BITS-1:0] window_mem [WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0] rd_ff;

   // Captured beat.
   req_type item_ff;

   // Record state.
   logic [LEN_BITS-1:0]  len_ff;
   logic [LEN_BITS-1:0]  len_in;
   logic [ADDR_BITS-1:0] slot_ff;
   logic [ADDR_BITS-1:0] slot_in;
   logic [LEN_BITS-1:0]  seen_ff;
   logic signed [SUM_BITS-1:0] sum_ff;
   logic signed [SUM_BITS-1:0] sum_in;
   logic signed [SUM_BITS-1:0] min_ff;
   logic signed [SUM_BITS-1:0] max_ff;
   logic full_ff;
   logic fill_ff;

   // Divider state.
   logic [DIV_BITS-1:0] quo_ff;
   logic [LEN_BITS-1:0] rem_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                had_ff;

   // Result register.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic [EXT_BITS-1:0] csr_ext;
   logic signed [SUM_BITS-1:0] sample_ext;
   logic signed [SUM_BITS-1:0] drop_val;
   logic                full_now;
   logic [LEN_BITS:0]   rem_sh;
   logic [SUM_BITS-1:0] diff;

   // Effective window length: zero counts as one, large values saturate.
   always_comb begin
      csr_ext = EXT_BITS'(csr_data);
      if (csr_ext == '0) begin
         len_in = LEN_BITS'(1);
      end else if (csr_ext > EXT_BITS'(WINDOW_MAX)) begin
         len_in = LEN_BITS'(WINDOW_MAX);
      end else begin
         len_in = LEN_BITS'(csr_ext);
      end
   end

   // New window sum and next slot.
   always_comb begin
      full_now   = seen_ff >= len_ff;
      sample_ext = SUM_BITS'(item_ff.sample);
      drop_val   = full_now ? SUM_BITS'(rd_ff) : '0;
      sum_in     = sum_ff + sample_ext - drop_val;
      if (LEN_BITS'(slot_ff) == len_ff - LEN_BITS'(1)) begin
         slot_in = '0;
      end else begin
         slot_in = slot_ff + ADDR_BITS'(1);
      end
   end

   // One restoring divide step and the dividend source.
   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIV_BITS-1]};
      diff   = SUM_BITS'(max_ff - min_ff);
   end

   // Delay line read and write.
   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rd_ff <= window_mem[slot_ff];
      end
      if (cmd.sum_update) begin
         window_mem[slot_ff] <= item_ff.sample;
      end
   end

   // Beat capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
   end

   // Record state: window length, slot, sum, count, min and max.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= LEN_BITS'(1);
         slot_ff <= '0;
         seen_ff <= '0;
         sum_ff  <= '0;
         min_ff  <= '0;
         max_ff  <= '0;
         full_ff <= 1'b0;
         fill_ff <= 1'b0;
      end else if (cmd.cfg_write || cmd.div_start) begin
         if (cmd.cfg_write) begin
            len_ff <= len_in;
         end
         slot_ff <= '0;
         seen_ff <= '0;
         sum_ff  <= '0;
         min_ff  <= '0;
         max_ff  <= '0;
      end else if (cmd.sum_update) begin
         sum_ff  <= sum_in;
         slot_ff <= slot_in;
         full_ff <= full_now;
         fill_ff <= !full_now && (seen_ff + LEN_BITS'(1) == len_ff);
         if (!full_now) begin
            seen_ff <= seen_ff + LEN_BITS'(1);
         end
      end else if (cmd.cmp_update) begin
         // The first full window seeds both extremes.
         if (full_ff) begin
            if (sum_ff < min_ff) begin
               min_ff <= sum_ff;
            end
            if (sum_ff > max_ff) begin
               max_ff <= sum_ff;
            end
         end else if (fill_ff) begin
            min_ff <= sum_ff;
            max_ff <= sum_ff;
         end
      end
   end

   // Serial divider, one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_start) begin
         cnt_ff <= CNT_BITS'(DIV_BITS - 1);
      end else if (cmd.div_step && cnt_ff != '0) begin
         cnt_ff <= cnt_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff <= {diff, FRAC_EXTRA'(0)};
         rem_ff <= '0;
         had_ff <= seen_ff >= len_ff;
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, len_ff}) begin
            rem_ff <= LEN_BITS'(rem_sh - {1'b0, len_ff});
            quo_ff <= {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= LEN_BITS'(rem_sh);
            quo_ff <= {quo_ff[DIV_BITS-2:0], 1'b0};
         end
      end
   end

   // Result register; a load wins over the beat being taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.avg_spread <= OUT_BITS'(quo_ff);
         rsp_data_ff.had_window <= had_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;
   assign status.item_last = item_ff.last;
   assign status.div_last  = cnt_ff == '0;
   assign status.out_busy  = rsp_valid_ff && rsp_stall;

`ifndef SYNTHESIS
   // The write slot always stays inside the window.
   assert property (@(posedge clock) disable iff (reset)
      LEN_BITS'(slot_ff) < len_ff)
      else $error("write slot outside the window");

   // The sample count saturates at the window length.
   assert property (@(posedge clock) disable iff (reset)
      seen_ff <= len_ff)
      else $error("sample count beyond the window length");

   // The extremes never cross.
   assert property (@(posedge clock) disable iff (reset)
      min_ff <= max_ff)
      else $error("minimum window sum above maximum");
`endif

endmodule

// ----- src/moving_average_range.sv -----
// Top level of the moving-average range block: joins the controller and
// the datapath. Depends on mar_pkg, mar_ctrl and mar_datapath.
//
// Each sample beat passes through a capture, a registered read of the
// delay line memory at the write slot, the running-sum update with the
// memory write, and the min/max compare. A beat marked last then goes on
// to the divider load, the restoring divider, which produces one quotient
// bit per cycle over SAMPLE_BITS + log2(WINDOW_MAX) + 9 bits, and the
// result load. The result waits in its own register, so the next record
// can start while it is stalled. The window length register is written
// only between beats; a write restarts the record. No clearing pass is
// needed after reset.
module moving_average_range (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  mar_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output mar_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [mar_pkg::CSR_BITS-1:0] csr_data
);
   import mar_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   mar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage and arithmetic.
   mar_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- dv/spread_checker.sv -----
`timescale 1ns / 100ps
// Checker for the moving-average range block: watches the sample, result and
// window-length channels, predicts each spread and compares it with the block.
// Depends on mar_pkg for the beat types and sizes.
module spread_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  mar_pkg::req_type             req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  mar_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [mar_pkg::CSR_BITS-1:0] csr_data,
   output int                           fail_count,
   output int                           pending
);
   import mar_pkg::*;

   // Predicted copy of the register and the record state.
   logic [CSR_BITS-1:0]           win_reg;
   logic signed [SAMPLE_BITS-1:0] delay_line [WINDOW_MAX];
   logic [ADDR_BITS-1:0]          next_slot;
   logic [LEN_BITS-1:0]           fill;
   logic signed [SUM_BITS-1:0]    win_sum;
   logic signed [SUM_BITS-1:0]    lo_sum;
   logic signed [SUM_BITS-1:0]    hi_sum;

   // Spreads predicted but not yet seen on the result channel.
   rsp_type spreads_due [$];
   int      bad = 0;

   // A zero length counts as one, and lengths past the delay line saturate.
   function automatic int span_of(input logic [CSR_BITS-1:0] reg_value);
      if (reg_value == 0) begin
         return 1;
      end
      if (reg_value > WINDOW_MAX) begin
         return WINDOW_MAX;
      end
      return int'(reg_value);
   endfunction

   task automatic restart_record();
      next_slot = '0;
      fill      = '0;
      win_sum   = '0;
      lo_sum    = '0;
      hi_sum    = '0;
   endtask

   // Move the window by one sample and queue a spread on the last beat.
   task automatic advance_window(input req_type beat);
      int                            span;
      int                            slot;
      logic signed [SAMPLE_BITS-1:0] value;
      logic [DIV_BITS-1:0]           diff;
      rsp_type                       spread;
      span  = span_of(win_reg);
      slot  = int'(next_slot) % span;
      value = beat.sample;
      if (fill >= span) begin
         win_sum = win_sum - delay_line[slot];
      end
      delay_line[slot] = value;
      win_sum          = win_sum + value;
      next_slot        = ADDR_BITS'((slot + 1) % span);
      if (fill >= span) begin
         if (win_sum < lo_sum) begin
            lo_sum = win_sum;
         end
         if (win_sum > hi_sum) begin
            hi_sum = win_sum;
         end
      end else begin
         fill = fill + 1'b1;
         if (fill == span) begin
            lo_sum = win_sum;
            hi_sum = win_sum;
         end
      end
      if (beat.last) begin
         // A record shorter than the window reports zero and no window.
         spread = '0;
         if (fill >= span) begin
            diff              = DIV_BITS'(hi_sum - lo_sum);
            spread.avg_spread = OUT_BITS'((diff << FRAC_EXTRA) / span);
            spread.had_window = 1'b1;
         end
         spreads_due = {spreads_due, spread};
         restart_record();
      end
   endtask

   task automatic note_mismatch(input string field, input int want, input int got);
      bad++;
      if (bad <= 10) begin
         $display("mismatch in %s: expected %0d, got %0d", field, want, got);
      end
   endtask

   // Compare each result beat with the oldest prediction.
   task automatic check_spread(input rsp_type got);
      rsp_type want;
      if (spreads_due.size() == 0) begin
         bad++;
         if (bad <= 10) begin
            $display("result beat with nothing predicted: avg_spread %0d had_window %0d",
                     got.avg_spread, got.had_window);
         end
      end else begin
         want = spreads_due.pop_front();
         if (got.avg_spread !== want.avg_spread) begin
            note_mismatch("avg_spread", int'(want.avg_spread), int'(got.avg_spread));
         end
         if (got.had_window !== want.had_window) begin
            note_mismatch("had_window", int'(want.had_window), int'(got.had_window));
         end
      end
   endtask

   // Follow every beat of the three channels at the clock edge.
   always @(posedge clock) begin
      if (reset) begin
         win_reg = 1;
         restart_record();
         spreads_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_spread(rsp_data);
         end
         if (csr_valid && csr_ready) begin
            win_reg = csr_data;
            restart_record();
         end
         if (req_valid && !req_stall) begin
            advance_window(req_data);
         end
      end
      pending    <= spreads_due.size();
      fail_count <= bad;
   end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Top of the moving-average range testbench: clock, reset, sample records,
// window-length writes and result stalls, plus the final verdict.
// Depends on mar_pkg, moving_average_range and spread_checker.
module testbench;
   import mar_pkg::*;

   localparam int ITEM_TARGET = 1200;
   localparam int QUIET_AFTER = 1000;
   localparam int SETTLE      = 64;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [CSR_BITS-1:0] csr_data;
   int                  fail_count;
   int                  pending;

   int items_sent   = 0;
   int records_sent = 0;
   bit quiet        = 0;

   moving_average_range u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   spread_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run ends here if the block stops making progress.
   initial begin
      #4_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   // Result stall comes in random bursts, and stops for the last part.
   initial begin
      int  run;
      bit  hold;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         run  = $urandom_range(1, 17);
         hold = !quiet && ($urandom_range(0, 2) == 0);
         rsp_stall <= hold;
         repeat (run) @(posedge clock);
      end
   end

   // Samples favor the extremes and small values around zero.
   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 5))
         0:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         1:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         2:       return SAMPLE_BITS'($urandom_range(0, 127) - 64);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // One sample beat, with an optional idle burst in front of it.
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value,
                              input logic is_last);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data.sample <= value;
      req_data.last   <= is_last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // The register is written only once every spread is out and the block
   // has had time to finish any beat still in flight.
   task automatic write_window_len(input logic [CSR_BITS-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // A record of random samples; a broken one never gets its last beat.
   task automatic send_record(input int len, input bit complete);
      for (int i = 0; i < len; i++) begin
         send_sample(pick_sample(), complete && (i == len - 1));
      end
      if (complete) begin
         records_sent++;
      end
   endtask

   initial begin
      logic [CSR_BITS-1:0] win;
      int                  span;
      int                  rec_count;
      int                  len;
      bit                  broken;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset length of one: full-scale swing, then a one-sample record.
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7fff, 1'b1);
      send_sample(16'sh0000, 1'b1);

      // A record shorter than the window reports no window.
      write_window_len(7'd4);
      send_sample(16'sh0005, 1'b0);
      send_sample(16'sh0007, 1'b1);

      // Largest possible spread for a window of four.
      for (int i = 0; i < 8; i++) begin
         send_sample((i < 4) ? 16'sh7fff : 16'sh8000, i == 7);
      end

      // A zero length acts as one.
      write_window_len(7'd0);
      send_sample(16'sh0064, 1'b0);
      send_sample(-16'sh0064, 1'b1);

      // A length past the delay line saturates to its depth.
      write_window_len(7'h7f);
      send_sample(16'sh0001, 1'b1);

      // A write in the middle of a record starts it over.
      write_window_len(7'd3);
      send_sample(-16'sh0001, 1'b0);
      send_sample(16'sh0001, 1'b0);
      write_window_len(7'd2);
      send_sample(16'sh0002, 1'b0);
      send_sample(16'sh0005, 1'b0);
      send_sample(16'sh0003, 1'b1);

      // Random phases: pick a length, then send a few records under it.
      while (items_sent < ITEM_TARGET || records_sent < 40) begin
         case ($urandom_range(0, 9))
            0:       win = 7'd1;
            1:       win = 7'd64;
            2:       win = 7'd0;
            3:       win = 7'h7f;
            4:       win = CSR_BITS'($urandom_range(65, 126));
            5:       win = CSR_BITS'($urandom_range(2, 64));
            default: win = CSR_BITS'($urandom_range(1, 8));
         endcase
         write_window_len(win);
         span      = (win == 0) ? 1 : ((win > WINDOW_MAX) ? WINDOW_MAX : int'(win));
         rec_count = $urandom_range(1, 4);
         for (int r = 0; r < rec_count; r++) begin
            case ($urandom_range(0, 7))
               0:       len = (span > 1) ? $urandom_range(1, span - 1) : 1;
               1:       len = span;
               default: len = span + $urandom_range(0, (span < 8) ? 12 : span / 2);
            endcase
            broken = (r == rec_count - 1) && ($urandom_range(0, 7) == 0);
            send_record(len, !broken);
         end
         if (items_sent > QUIET_AFTER) begin
            quiet = 1'b1;
         end
      end

      // Drain: every predicted spread must arrive, then let the block settle.
      quiet = 1'b1;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
